// ===== rtl/core/vfr_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the velocity frame receiver.
package vfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] CRC_POLY   = 8'h8C;

    localparam int STORE_DEPTH = 13;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_CHECK,
        PH_TAIL0,
        PH_TAIL1
    } phase_t;

    // One received byte with its header classification.
    typedef struct packed {
        logic [7:0] data;
        logic       is_second;
    } rx_item_t;

    // Reflected CRC-8, LSB first, no final xor.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    localparam logic [7:0] HDR_CRC = crc8_step(crc8_step(8'h00, HDR_FIRST), HDR_SECOND);

endpackage

// ===== rtl/core/vfr_front.sv =====
// Front end: accepts received bytes, tags AA header bytes and pushes to the queue.
module vfr_front (
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                queue_full,
    output logic                push,
    output vfr_pkg::rx_item_t   push_item
);

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_item.data      = rx_byte;
        push_item.is_second = (rx_byte == vfr_pkg::HDR_SECOND);
    end

endmodule

// ===== rtl/core/vfr_queue.sv =====
// Short queue of classified bytes between the front end and the frame engine.
module vfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vfr_pkg::rx_item_t   push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output vfr_pkg::rx_item_t   head_item
);

    vfr_pkg::rx_item_t                  entry_reg [vfr_pkg::QUEUE_DEPTH];
    logic [vfr_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [vfr_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [vfr_pkg::QCNT_W-1:0]         count_reg, count_next;

    assign full       = (count_reg == vfr_pkg::QCNT_W'(vfr_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/vfr_back.sv =====
// Frame engine: phase tracking, running CRC, payload store and the result register.
module vfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  vfr_pkg::rx_item_t   head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                status,
    output logic [31:0]         vel_x_bits,
    output logic [31:0]         vel_y_bits,
    output logic [31:0]         yaw_rate_bits,
    output logic [7:0]          control_flag
);

    vfr_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]         prev_reg, prev_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         count_reg, count_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         store_reg [vfr_pkg::STORE_DEPTH];
    logic [7:0]         store_next [vfr_pkg::STORE_DEPTH];

    logic               out_valid_reg, out_valid_next;
    logic               status_reg, status_next;
    logic [31:0]        vel_x_reg, vel_x_next;
    logic [31:0]        vel_y_reg, vel_y_next;
    logic [31:0]        yaw_reg, yaw_next;
    logic [7:0]         flag_reg, flag_next;

    logic               emit;
    logic [7:0]         b;
    logic [7:0]         crc_of_b;
    logic [8:0]         count_inc;

    // Take a beat whenever the result register is free or draining this cycle.
    assign pop       = head_valid && (!out_valid_reg || !out_stall);
    assign b         = head_item.data;
    assign crc_of_b  = vfr_pkg::crc8_step(crc_reg, b);
    assign count_inc = {1'b0, count_reg} + 9'd1;

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign vel_x_bits    = vel_x_reg;
    assign vel_y_bits    = vel_y_reg;
    assign yaw_rate_bits = yaw_reg;
    assign control_flag  = flag_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        prev_next   = prev_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        store_next  = store_reg;
        emit        = 1'b0;
        status_next = status_reg;
        vel_x_next  = vel_x_reg;
        vel_y_next  = vel_y_reg;
        yaw_next    = yaw_reg;
        flag_next   = flag_reg;

        if (pop)
        begin
            unique case (phase_reg)
                vfr_pkg::PH_LEN:
                begin
                    len_next   = b;
                    crc_next   = crc_of_b;
                    count_next = '0;
                    phase_next = vfr_pkg::PH_DATA;
                end
                vfr_pkg::PH_DATA:
                begin
                    if (count_reg < 8'(vfr_pkg::STORE_DEPTH))
                    begin
                        store_next[count_reg[vfr_pkg::STORE_IDX_W-1:0]] = b;
                    end
                    // A zero length still eats one byte, kept out of the CRC.
                    if (len_reg != 8'd0)
                    begin
                        crc_next = crc_of_b;
                    end
                    if (count_inc >= {1'b0, len_reg})
                    begin
                        phase_next = vfr_pkg::PH_CHECK;
                    end
                    count_next = count_inc[7:0];
                end
                vfr_pkg::PH_CHECK:
                begin
                    if (len_reg < 8'(vfr_pkg::STORE_DEPTH))
                    begin
                        store_next[len_reg[vfr_pkg::STORE_IDX_W-1:0]] = b;
                    end
                    if (b != crc_reg)
                    begin
                        emit        = 1'b1;
                        status_next = 1'b1;
                        vel_x_next  = '0;
                        vel_y_next  = '0;
                        yaw_next    = '0;
                        flag_next   = '0;
                        phase_next  = vfr_pkg::PH_HUNT;
                        prev_next   = '0;
                        len_next    = '0;
                        count_next  = '0;
                        crc_next    = '0;
                    end
                    else
                    begin
                        phase_next = vfr_pkg::PH_TAIL0;
                    end
                end
                vfr_pkg::PH_TAIL0:
                begin
                    phase_next = vfr_pkg::PH_TAIL1;
                end
                vfr_pkg::PH_TAIL1:
                begin
                    emit        = 1'b1;
                    status_next = 1'b0;
                    vel_x_next  = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
                    vel_y_next  = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
                    yaw_next    = {store_reg[11], store_reg[10], store_reg[9], store_reg[8]};
                    flag_next   = store_reg[12];
                    phase_next  = vfr_pkg::PH_HUNT;
                    prev_next   = '0;
                    len_next    = '0;
                    count_next  = '0;
                    crc_next    = '0;
                end
                default:
                begin
                    // Hunt: AA after 55 opens a frame; AA never replaces the last byte.
                    if (head_item.is_second)
                    begin
                        if (prev_reg == vfr_pkg::HDR_FIRST)
                        begin
                            crc_next   = vfr_pkg::HDR_CRC;
                            count_next = '0;
                            phase_next = vfr_pkg::PH_LEN;
                        end
                    end
                    else
                    begin
                        prev_next = b;
                    end
                end
            endcase
        end

        if (pop)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= vfr_pkg::PH_HUNT;
            prev_reg      <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < vfr_pkg::STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            store_reg     <= store_next;
        end
    end

    // Result payload loads only when a result is produced.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= status_next;
            vel_x_reg  <= vel_x_next;
            vel_y_reg  <= vel_y_next;
            yaw_reg    <= yaw_next;
            flag_reg   <= flag_next;
        end
    end

endmodule

// ===== rtl/core/velocity_frame_receiver_top.sv =====
// Velocity frame receiver: byte-stream deframer with CRC-8 check, top level.
//
// Input channel: one received byte per beat on rx_byte, with in_valid/in_stall.
// Output channel: one result per frame on out_valid/out_stall: status 0 with
// the three little-endian 32-bit words and the flag byte for a good frame, or
// status 1 with zero data when the checksum byte mismatches.
// Frames are 55 AA len payload[len] crc t0 t1; the trailer is not checked.
// Throughput: one byte per cycle while out_stall is low. The front end tags
// the AA header bytes into a four-entry queue; the frame engine retires one
// queued byte per cycle unless a stalled result holds it. A frame's last
// byte is written to the queue, then the engine takes it and loads the
// result register behind out_valid; earlier bytes still queued delay it more.
// Reset clears the phase, counters, CRC, payload store and queue; the block
// starts hunting for a header and accepts bytes right away.
// While out_stall holds a valid result, the result register and the engine hold;
// bytes keep landing in the queue, and in_stall rises once four beats fill it.
module velocity_frame_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [31:0] vel_x_bits,
    output logic [31:0] vel_y_bits,
    output logic [31:0] yaw_rate_bits,
    output logic [7:0]  control_flag
);

    logic               queue_full;
    logic               push;
    vfr_pkg::rx_item_t  push_item;
    logic               pop;
    logic               head_valid;
    vfr_pkg::rx_item_t  head_item;

    vfr_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    vfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    vfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .vel_x_bits    (vel_x_bits),
        .vel_y_bits    (vel_y_bits),
        .yaw_rate_bits (yaw_rate_bits),
        .control_flag  (control_flag)
    );

endmodule

// ===== test/tb_velocity_frame_receiver_top.sv =====
// Testbench for velocity_frame_receiver_top: framed byte stream against a frame predictor.
`timescale 1ns / 100ps

module tb_velocity_frame_receiver_top;
    import vfr_pkg::*;

    typedef struct packed {
        bit        status;
        bit [31:0] vel_x;
        bit [31:0] vel_y;
        bit [31:0] yaw_rate;
        bit [7:0]  flag;
    } frame_result_t;

    typedef enum bit [1:0] {
        FILL_CONST,
        FILL_INC,
        FILL_RAND
    } fill_t;

    // One directed frame: leading noise bytes (LSB first), frame shape, trailer count.
    typedef struct packed {
        bit [31:0]     noise;
        bit [2:0]      noise_n;
        bit [7:0]      len;
        fill_t         how;
        bit [7:0]      seed;
        bit [7:0]      crc_flip;
        bit [1:0]      trail_n;
        bit            typed;
        frame_result_t want;
    } frame_row_t;

    localparam int NUM_ROWS = 13;

    localparam frame_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{32'h0, 3'd0, 8'd13, FILL_CONST, 8'hFF, 8'h00, 2'd2, 1'b1,
          '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}},
        '{32'h0, 3'd0, 8'd13, FILL_CONST, 8'h00, 8'h00, 2'd2, 1'b1,
          '{1'b0, 32'h0, 32'h0, 32'h0, 8'h00}},
        '{32'h0, 3'd0, 8'd13, FILL_INC, 8'h00, 8'h00, 2'd2, 1'b1,
          '{1'b0, 32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908, 8'h0C}},
        '{32'h0, 3'd0, 8'd1, FILL_CONST, 8'h5A, 8'h01, 2'd0, 1'b1,
          '{1'b1, 32'h0, 32'h0, 32'h0, 8'h00}},
        '{32'h0, 3'd0, 8'd0, FILL_CONST, 8'h77, 8'h00, 2'd2, 1'b0, '0},
        '{32'h0, 3'd0, 8'd0, FILL_CONST, 8'hC3, 8'h80, 2'd2, 1'b1,
          '{1'b1, 32'h0, 32'h0, 32'h0, 8'h00}},
        '{32'h0, 3'd0, 8'd4, FILL_INC, 8'h40, 8'h00, 2'd2, 1'b0, '0},
        '{32'h0, 3'd0, 8'd12, FILL_CONST, 8'h11, 8'h00, 2'd2, 1'b0, '0},
        '{32'h0, 3'd0, 8'd20, FILL_RAND, 8'h00, 8'h00, 2'd2, 1'b0, '0},
        '{32'h0, 3'd0, 8'd16, FILL_RAND, 8'h00, 8'hFF, 2'd1, 1'b1,
          '{1'b1, 32'h0, 32'h0, 32'h0, 8'h00}},
        '{32'hAA33_55AA, 3'd4, 8'd5, FILL_INC, 8'hF0, 8'h00, 2'd2, 1'b0, '0},
        '{32'h0000_5555, 3'd2, 8'd2, FILL_CONST, 8'h80, 8'h00, 2'd2, 1'b0, '0},
        '{32'h0, 3'd0, 8'd13, FILL_RAND, 8'h00, 8'h00, 2'd2, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic [31:0] vel_x_bits;
    logic [31:0] vel_y_bits;
    logic [31:0] yaw_rate_bits;
    logic [7:0]  control_flag;

    velocity_frame_receiver_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .vel_x_bits    (vel_x_bits),
        .vel_y_bits    (vel_y_bits),
        .yaw_rate_bits (yaw_rate_bits),
        .control_flag  (control_flag)
    );

    // Deframer state as the predictor sees it
    phase_t        rx_phase;
    bit [7:0]      prev_byte;
    bit [7:0]      frame_len;
    bit [7:0]      data_count;
    bit [7:0]      crc_acc;
    bit [7:0]      slot_bytes [STORE_DEPTH];

    frame_result_t pending_frames [$];
    bit            typed_on;
    frame_result_t typed_want;
    int            mismatch_count = 0;
    int            framed_bytes   = 0;
    int            gap_odds       = 0;
    int            stall_odds     = 0;
    bit            quiet          = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_velocity_frame_receiver_top failed");
        $finish;
    end

    // Reflected CRC-8, one data bit at a time
    function automatic bit [7:0] crc8_next(input bit [7:0] acc, input bit [7:0] d);
        bit [7:0] r;
        bit       fb;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            fb = r[0] ^ d[k];
            r  = r >> 1;
            if (fb)
                r = r ^ 8'h8C;
        end
        return r;
    endfunction

    function automatic bit [7:0] noise_byte();
        case ($urandom_range(3))
            0:       return HDR_FIRST;
            1:       return HDR_SECOND;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input bit [31:0] got,
                                   input bit [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic restart_hunt();
        rx_phase   = PH_HUNT;
        prev_byte  = 8'h00;
        frame_len  = 8'h00;
        data_count = 8'h00;
        crc_acc    = 8'h00;
    endtask

    function automatic bit [31:0] slot_word(input int base);
        return {slot_bytes[base + 3], slot_bytes[base + 2],
                slot_bytes[base + 1], slot_bytes[base]};
    endfunction

    task automatic step_deframer(input bit [7:0] b, output bit fired,
                                 output frame_result_t res);
        fired = 1'b0;
        res   = '0;
        case (rx_phase)
            PH_LEN:
            begin
                frame_len  = b;
                crc_acc    = crc8_next(crc_acc, b);
                data_count = 8'h00;
                rx_phase   = PH_DATA;
            end
            PH_DATA:
            begin
                if (data_count < STORE_DEPTH)
                    slot_bytes[data_count] = b;
                // a zero-length frame still eats one byte, outside the CRC
                if (frame_len != 8'h00)
                    crc_acc = crc8_next(crc_acc, b);
                if (int'(data_count) + 1 >= int'(frame_len))
                    rx_phase = PH_CHECK;
                data_count = data_count + 8'h01;
            end
            PH_CHECK:
            begin
                if (frame_len < STORE_DEPTH)
                    slot_bytes[frame_len] = b;
                if (b != crc_acc)
                begin
                    fired      = 1'b1;
                    res.status = 1'b1;
                    restart_hunt();
                end
                else
                    rx_phase = PH_TAIL0;
            end
            PH_TAIL0:
                rx_phase = PH_TAIL1;
            PH_TAIL1:
            begin
                fired        = 1'b1;
                res.vel_x    = slot_word(0);
                res.vel_y    = slot_word(4);
                res.yaw_rate = slot_word(8);
                res.flag     = slot_bytes[12];
                restart_hunt();
            end
            default:
            begin
                if (b == HDR_SECOND)
                begin
                    if (prev_byte == HDR_FIRST)
                    begin
                        crc_acc    = crc8_next(crc8_next(8'h00, HDR_FIRST), HDR_SECOND);
                        data_count = 8'h00;
                        rx_phase   = PH_LEN;
                    end
                end
                else
                    prev_byte = b;
            end
        endcase
    endtask

    // Enter right after a rising edge; leave right after the accepting edge.
    task automatic drive_byte(input bit [7:0] b);
        bit            fired;
        frame_result_t res;
        if (!quiet && gap_odds != 0 && $urandom_range(gap_odds - 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_deframer(b, fired, res);
        if (fired)
            pending_frames.push_back(typed_on ? typed_want : res);
    endtask

    task automatic send_frame(input bit [7:0] len, input fill_t how, input bit [7:0] seed,
                              input bit [7:0] crc_flip, input int trail_n);
        bit [7:0] crc;
        bit [7:0] d;
        int       n;
        crc = crc8_next(crc8_next(8'h00, HDR_FIRST), HDR_SECOND);
        drive_byte(HDR_FIRST);
        drive_byte(HDR_SECOND);
        drive_byte(len);
        crc = crc8_next(crc, len);
        n   = (len == 8'h00) ? 1 : int'(len);
        for (int i = 0; i < n; i++)
        begin
            case (how)
                FILL_CONST: d = seed;
                FILL_INC:   d = seed + i[7:0];
                default:    d = 8'($urandom);
            endcase
            if (len != 8'h00)
                crc = crc8_next(crc, d);
            drive_byte(d);
        end
        drive_byte(crc ^ crc_flip);
        repeat (trail_n) drive_byte(8'($urandom));
        framed_bytes += n + 4 + trail_n;
    endtask

    // Receiver side: random stall bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet || stall_odds == 0 || $urandom_range(stall_odds - 1) != 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16) - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        frame_result_t got;
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, vel_x_bits, vel_y_bits, yaw_rate_bits, control_flag};
            if (pending_frames.size() == 0)
                report_mismatch("result with no frame pending", 32'(got.status), 32'h0);
            else
            begin
                want = pending_frames.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.vel_x != want.vel_x)
                    report_mismatch("vel_x_bits", got.vel_x, want.vel_x);
                if (got.vel_y != want.vel_y)
                    report_mismatch("vel_y_bits", got.vel_y, want.vel_y);
                if (got.yaw_rate != want.yaw_rate)
                    report_mismatch("yaw_rate_bits", got.yaw_rate, want.yaw_rate);
                if (got.flag != want.flag)
                    report_mismatch("control_flag", 32'(got.flag), 32'(want.flag));
            end
        end
    end

    initial
    begin : stimulus
        frame_row_t row;
        int         pick;
        int         len;
        bit [7:0]   flip;
        int         wait_cycles;

        restart_hunt();
        foreach (slot_bytes[i])
            slot_bytes[i] = 8'h00;
        typed_on = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds   = 4;
        stall_odds = 4;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            for (int k = 0; k < int'(row.noise_n); k++)
                drive_byte(row.noise[8 * k +: 8]);
            typed_on   = row.typed;
            typed_want = row.want;
            send_frame(row.len, row.how, row.seed, row.crc_flip, row.trail_n);
            typed_on = 1'b0;
        end

        while (framed_bytes < 2000)
        begin
            case ($urandom_range(3))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 12;
            endcase
            case ($urandom_range(3))
                0:       stall_odds = 0;
                1:       stall_odds = 3;
                default: stall_odds = 10;
            endcase
            quiet = (framed_bytes > 1700);
            pick  = $urandom_range(99);
            if (pick < 12)
            begin
                repeat ($urandom_range(1, 8)) drive_byte(noise_byte());
            end
            else if (pick < 22)
            begin
                // cut a frame short and let the next bytes fall into it
                len = $urandom_range(0, 20);
                drive_byte(HDR_FIRST);
                drive_byte(HDR_SECOND);
                drive_byte(len[7:0]);
                repeat ($urandom_range(0, len)) drive_byte(8'($urandom));
                framed_bytes += len + 3;
            end
            else
            begin
                repeat ($urandom_range(2)) drive_byte(noise_byte());
                pick = $urandom_range(99);
                if (pick < 3)
                    len = 255;
                else if (pick < 15)
                    len = $urandom_range(14, 40);
                else
                    len = $urandom_range(0, 13);
                flip = ($urandom_range(6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_frame(len[7:0], FILL_RAND, 8'h00, flip,
                           (flip != 8'h00) ? $urandom_range(2) : 2);
            end
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_frames.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);

        if (pending_frames.size() != 0)
            report_mismatch("frames never delivered", pending_frames.size(), 32'h0);
        if (mismatch_count == 0)
            $display("tb_velocity_frame_receiver_top passed");
        else
            $display("tb_velocity_frame_receiver_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vfr_pkg.sv
rtl/core/vfr_front.sv
rtl/core/vfr_queue.sv
rtl/core/vfr_back.sv
rtl/core/velocity_frame_receiver_top.sv
test/tb_velocity_frame_receiver_top.sv
